// ----- rtl/core/mvsp_pkg.sv -----
// ----------------------------------------------------------------------------
// mvsp_pkg
// Shared types and constants for the MAVLink v2 frame splitter.
// ----------------------------------------------------------------------------
package mvsp_pkg;

    localparam int POS_W = 9;

    localparam logic [POS_W-1:0] PREFIX_LEN = 9'd48;
    localparam logic [POS_W-1:0] HEADER_LEN = 9'd10;
    localparam logic [POS_W-1:0] CRC_LEN    = 9'd2;

    localparam logic [POS_W-1:0] OFS_MARKER   = 9'd0;
    localparam logic [POS_W-1:0] OFS_LENGTH   = 9'd1;
    localparam logic [POS_W-1:0] OFS_INCOMPAT = 9'd2;
    localparam logic [POS_W-1:0] OFS_COMPAT   = 9'd3;
    localparam logic [POS_W-1:0] OFS_SEQ      = 9'd4;
    localparam logic [POS_W-1:0] OFS_SYS      = 9'd5;
    localparam logic [POS_W-1:0] OFS_COMP     = 9'd6;
    localparam logic [POS_W-1:0] OFS_MSGID    = 9'd7;

    localparam int TDATA_W = 72;
    localparam int TUSER_W = 4;

    typedef enum logic [3:0] {
        KIND_PREFIX   = 4'd0,
        KIND_MARKER   = 4'd1,
        KIND_LENGTH   = 4'd2,
        KIND_INCOMPAT = 4'd3,
        KIND_COMPAT   = 4'd4,
        KIND_SEQ      = 4'd5,
        KIND_SYS      = 4'd6,
        KIND_COMP     = 4'd7,
        KIND_MSGID    = 4'd8,
        KIND_PAYLOAD  = 4'd9,
        KIND_CRC      = 4'd10
    } field_kind_t;

    typedef struct packed {
        logic [7:0]  component_id;
        logic [7:0]  system_id;
        logic [7:0]  sequence_res;
        logic [7:0]  payload_length;
        logic [23:0] msg_id;
        logic        frame_last;
        logic [7:0]  field_index;
        field_kind_t field_kind;
        logic [7:0]  out_byte;
    } mvsp_result_t;

endpackage

// ----- rtl/core/mvsp_tracker.sv -----
// ----------------------------------------------------------------------------
// mvsp_tracker
// Frame position counter, held header fields and per-byte field decode.
// ----------------------------------------------------------------------------
module mvsp_tracker
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic                step,
    input  logic [7:0]          in_byte,
    output mvsp_pkg::mvsp_result_t result
);

    logic                        mode_reg;
    logic [mvsp_pkg::POS_W-1:0]  pos_reg;
    logic [mvsp_pkg::POS_W-1:0]  pos_next;
    logic [7:0]                  length_reg;
    logic [7:0]                  length_next;
    logic [7:0]                  seq_reg;
    logic [7:0]                  seq_next;
    logic [7:0]                  sys_reg;
    logic [7:0]                  sys_next;
    logic [7:0]                  comp_reg;
    logic [7:0]                  comp_next;
    logic [23:0]                 msgid_reg;
    logic [23:0]                 msgid_next;

    logic [mvsp_pkg::POS_W-1:0]  start;
    logic [mvsp_pkg::POS_W-1:0]  rel;
    logic [mvsp_pkg::POS_W-1:0]  mid;
    logic [mvsp_pkg::POS_W-1:0]  pay_idx;
    logic [mvsp_pkg::POS_W-1:0]  crc_idx;
    logic [mvsp_pkg::POS_W:0]    pay_end;
    logic [mvsp_pkg::POS_W:0]    frame_end;
    logic [mvsp_pkg::POS_W:0]    rel_plus;
    logic                        in_prefix;
    logic                        last;
    mvsp_pkg::field_kind_t       kind;
    logic [7:0]                  idx;

    always_comb
    begin
        start       = mode_reg ? mvsp_pkg::PREFIX_LEN : '0;
        in_prefix   = pos_reg < start;
        rel         = pos_reg - start;
        mid         = rel - mvsp_pkg::OFS_MSGID;
        length_next = (rel == mvsp_pkg::OFS_LENGTH && !in_prefix) ? in_byte : length_reg;
        seq_next    = (rel == mvsp_pkg::OFS_SEQ && !in_prefix) ? in_byte : seq_reg;
        sys_next    = (rel == mvsp_pkg::OFS_SYS && !in_prefix) ? in_byte : sys_reg;
        comp_next   = (rel == mvsp_pkg::OFS_COMP && !in_prefix) ? in_byte : comp_reg;
        pay_idx     = rel - mvsp_pkg::HEADER_LEN;
        crc_idx     = pay_idx - {1'b0, length_next};
        pay_end     = {1'b0, mvsp_pkg::HEADER_LEN} + {2'b00, length_next};
        frame_end   = pay_end + {1'b0, mvsp_pkg::CRC_LEN};
        rel_plus    = {1'b0, rel} + 10'd1;
        msgid_next  = msgid_reg;
        kind        = mvsp_pkg::KIND_PREFIX;
        idx         = '0;

        priority if (in_prefix)
        begin
            kind = mvsp_pkg::KIND_PREFIX;
            idx  = pos_reg[7:0];
        end
        else if (rel == mvsp_pkg::OFS_MARKER)
            kind = mvsp_pkg::KIND_MARKER;
        else if (rel == mvsp_pkg::OFS_LENGTH)
            kind = mvsp_pkg::KIND_LENGTH;
        else if (rel == mvsp_pkg::OFS_INCOMPAT)
            kind = mvsp_pkg::KIND_INCOMPAT;
        else if (rel == mvsp_pkg::OFS_COMPAT)
            kind = mvsp_pkg::KIND_COMPAT;
        else if (rel == mvsp_pkg::OFS_SEQ)
            kind = mvsp_pkg::KIND_SEQ;
        else if (rel == mvsp_pkg::OFS_SYS)
            kind = mvsp_pkg::KIND_SYS;
        else if (rel == mvsp_pkg::OFS_COMP)
            kind = mvsp_pkg::KIND_COMP;
        else if (rel < mvsp_pkg::HEADER_LEN)
        begin
            kind = mvsp_pkg::KIND_MSGID;
            idx  = mid[7:0];
            unique case (mid[1:0])
                2'd0:    msgid_next[7:0]   = in_byte;
                2'd1:    msgid_next[15:8]  = in_byte;
                2'd2:    msgid_next[23:16] = in_byte;
                default: msgid_next        = msgid_reg;
            endcase
        end
        else if ({1'b0, rel} < pay_end)
        begin
            kind = mvsp_pkg::KIND_PAYLOAD;
            idx  = pay_idx[7:0];
        end
        else
        begin
            kind = mvsp_pkg::KIND_CRC;
            idx  = crc_idx[7:0];
        end

        last     = !in_prefix && (rel_plus >= frame_end);
        pos_next = last ? '0 : pos_reg + 9'd1;

        result.out_byte       = in_byte;
        result.field_kind     = kind;
        result.field_index    = idx;
        result.frame_last     = last;
        result.msg_id         = last ? msgid_next : '0;
        result.payload_length = last ? length_next : '0;
        result.sequence_res   = last ? seq_next : '0;
        result.system_id      = last ? sys_next : '0;
        result.component_id   = last ? comp_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            pos_reg    <= '0;
            length_reg <= '0;
            seq_reg    <= '0;
            sys_reg    <= '0;
            comp_reg   <= '0;
            msgid_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            mode_reg   <= cfg_wr_data;
            pos_reg    <= '0;
            length_reg <= '0;
            seq_reg    <= '0;
            sys_reg    <= '0;
            comp_reg   <= '0;
            msgid_reg  <= '0;
        end
        else if (step)
        begin
            pos_reg    <= pos_next;
            length_reg <= length_next;
            seq_reg    <= seq_next;
            sys_reg    <= sys_next;
            comp_reg   <= comp_next;
            msgid_reg  <= msgid_next;
        end
    end

endmodule

// ----- rtl/core/mavlink_v2_frame_splitter_core.sv -----
// ----------------------------------------------------------------------------
// mavlink_v2_frame_splitter_core
// Tags each byte of a MAVLink v2 stream with its field and index.
// ----------------------------------------------------------------------------
// Pipeline: input register, then result register; a stalled output holds the byte in the input register.
// Throughput: one byte per cycle while m_axis_tready is high; the position counter and compares are combinational.
// Reset: rst_n clears mode, frame position, held header fields and both valid flags.
// A configuration write restarts framing at the first byte of a new frame.
module mavlink_v2_frame_splitter_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // in_byte
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out_byte, field_index, msg_id, payload_length, sequence_res, system_id, component_id
    output logic [mvsp_pkg::TDATA_W-1:0]  m_axis_tdata,
    output logic [mvsp_pkg::TUSER_W-1:0]  m_axis_tuser,   // field_kind
    output logic                          m_axis_tlast    // frame_last
);

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   out_valid_reg;
    mvsp_pkg::mvsp_result_t out_result_reg;
    mvsp_pkg::mvsp_result_t result;
    logic                   advance;
    logic                   s_accept;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    mvsp_tracker u_tracker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (advance),
        .in_byte     (in_byte_reg),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_accept)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
            in_byte_reg <= s_axis_tdata;
        if (advance)
            out_result_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_result_reg.frame_last;
    assign m_axis_tuser  = out_result_reg.field_kind;
    assign m_axis_tdata  = {out_result_reg.component_id,
                            out_result_reg.system_id,
                            out_result_reg.sequence_res,
                            out_result_reg.payload_length,
                            out_result_reg.msg_id,
                            out_result_reg.field_index,
                            out_result_reg.out_byte};

    a_last_is_crc : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == mvsp_pkg::KIND_CRC)
        else $error("frame end on a non-checksum byte");

    a_ids_zero_mid_frame : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[71:16] == '0)
        else $error("frame values shown before frame end");

    a_advance_fills_out : assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced word not held in result register");

    a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |-> !advance)
        else $error("result register overwritten while stalled");

endmodule
